// File: rtl/core/prc_pkg.sv
`timescale 1ns / 1ps

package prc_pkg;

	localparam int OUT_CHANNELS = 6;
	localparam int RAW_W        = 12;
	localparam int TICK_W       = 16;
	localparam int ORDER_W      = 3;
	localparam int MAP_W        = ORDER_W * OUT_CHANNELS;
	localparam int CMD_W        = 10;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 18;

	localparam logic [RAW_W-1:0]  RAW_MAX    = 12'd4095;
	localparam logic [RAW_W-1:0]  RAW_RESET  = 12'd1500;
	localparam logic [RAW_W-1:0]  RAW_LOW    = 12'd1000;
	localparam logic [RAW_W-1:0]  RAW_MID    = 12'd1500;
	localparam logic [RAW_W-1:0]  RAW_HIGH   = 12'd2000;
	localparam logic [CMD_W-1:0]  THR_MIN    = 10'd0;
	localparam logic [CMD_W-1:0]  THR_MAX    = 10'd1000;
	localparam logic [CMD_W-1:0]  AXIS_MIN   = 10'b1000001100;
	localparam logic [CMD_W-1:0]  AXIS_MAX   = 10'd500;

	localparam logic [MAP_W-1:0]  MAP_RESET  = 18'd181896;
	localparam logic [TICK_W-1:0] SYNC_RESET = 16'd5000;
	localparam logic [TICK_W-1:0] MIN_RESET  = 16'd500;
	localparam logic [TICK_W-1:0] MAX_RESET  = 16'd2500;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORDER_MAP = 2'd0,
		REG_SYNC_GAP  = 2'd1,
		REG_PULSE_MIN = 2'd2,
		REG_PULSE_MAX = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [OUT_CHANNELS-1:0]            upd;
		logic [OUT_CHANNELS-1:0][RAW_W-1:0] raw;
	} poll_entry_t;

endpackage

// File: rtl/core/prc_front.sv
`timescale 1ns / 1ps

module prc_front
	import prc_pkg::*;
#(
	parameter int NUM_CHANNELS = 6
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  req_type,
	input  logic [TICK_W-1:0]     timestamp,
	input  logic                  pin_high,
	output logic                  q_push,
	output poll_entry_t           q_entry,
	input  logic                  q_full
);

	localparam int SLOT_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int IDX_W  = $clog2(NUM_CHANNELS + 1);
	localparam logic [ORDER_W-1:0] SRC_MAX = ORDER_W'(NUM_CHANNELS - 1);
	localparam logic [IDX_W-1:0]   IDX_END = IDX_W'(NUM_CHANNELS);

	logic [MAP_W-1:0]        map_q;
	logic [TICK_W-1:0]       sync_q;
	logic [TICK_W-1:0]       min_q;
	logic [TICK_W-1:0]       max_q;
	logic [TICK_W-1:0]       last_q;
	logic [IDX_W-1:0]        idx_q;
	logic [RAW_W-1:0]        raw_q [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0] fresh_q;
	logic [RAW_W-1:0]        buf_q [OUT_CHANNELS];

	logic                    edge_go;
	logic                    poll_go;
	logic [TICK_W-1:0]       gap;
	logic [RAW_W-1:0]        gap_sat;
	logic [NUM_CHANNELS-1:0] fresh_poll;
	logic [OUT_CHANNELS-1:0] upd;
	logic [SLOT_W-1:0]       src_sel [OUT_CHANNELS];
	logic [RAW_W-1:0]        raw_sel [OUT_CHANNELS];
	logic [ORDER_W-1:0]      src3;
	logic                    near;

	assign in_ready = !q_full;
	assign edge_go  = in_valid && in_ready && !req_type && pin_high;
	assign poll_go  = in_valid && in_ready && req_type;
	assign gap      = timestamp - last_q;
	assign gap_sat  = (gap > TICK_W'(RAW_MAX)) ? RAW_MAX : gap[RAW_W-1:0];

	// slots are walked in channel order so a repeated source sees earlier clears
	always_comb begin
		fresh_poll = fresh_q;
		src3       = '0;
		near       = 1'b0;
		for (int i = 0; i < OUT_CHANNELS; i++) begin
			src3       = map_q[ORDER_W*i +: ORDER_W];
			src_sel[i] = (src3 > SRC_MAX) ? SRC_MAX[SLOT_W-1:0] : src3[SLOT_W-1:0];
			raw_sel[i] = raw_q[src_sel[i]];
			near = !(({1'b0, buf_q[i]} > {1'b0, raw_sel[i]} + 13'd1) ||
			         ({1'b0, raw_sel[i]} > {1'b0, buf_q[i]} + 13'd1));
			upd[i] = fresh_poll[src_sel[i]] && !near;
			if (upd[i]) begin
				fresh_poll[src_sel[i]] = 1'b0;
			end
		end
	end

	assign q_push = poll_go;
	always_comb begin
		q_entry.upd = upd;
		for (int i = 0; i < OUT_CHANNELS; i++) begin
			q_entry.raw[i] = raw_sel[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q   <= MAP_RESET;
			sync_q  <= SYNC_RESET;
			min_q   <= MIN_RESET;
			max_q   <= MAX_RESET;
			last_q  <= '0;
			idx_q   <= '0;
			fresh_q <= '1;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				raw_q[i] <= RAW_RESET;
			end
			for (int i = 0; i < OUT_CHANNELS; i++) begin
				buf_q[i] <= RAW_RESET;
			end
		end else begin
			if (wr_en) begin
				unique case (cfg_reg_t'(wr_index))
					REG_ORDER_MAP: map_q  <= wr_data[MAP_W-1:0];
					REG_SYNC_GAP:  sync_q <= wr_data[TICK_W-1:0];
					REG_PULSE_MIN: min_q  <= wr_data[TICK_W-1:0];
					REG_PULSE_MAX: max_q  <= wr_data[TICK_W-1:0];
					default: ;
				endcase
			end
			if (edge_go) begin
				last_q <= timestamp;
				if (gap > sync_q) begin
					idx_q <= '0;
				end else if (gap > min_q && gap < max_q && idx_q < IDX_END) begin
					fresh_q[idx_q[SLOT_W-1:0]] <= 1'b1;
					raw_q[idx_q[SLOT_W-1:0]]   <= gap_sat;
					idx_q                      <= idx_q + IDX_W'(1);
				end
			end
			if (poll_go) begin
				fresh_q <= fresh_poll;
				for (int i = 0; i < OUT_CHANNELS; i++) begin
					if (upd[i]) begin
						buf_q[i] <= raw_sel[i];
					end
				end
			end
		end
	end

endmodule

// File: rtl/core/prc_queue.sv
`timescale 1ns / 1ps

module prc_queue
	import prc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  poll_entry_t push_entry,
	output logic        full,
	output logic        valid,
	output poll_entry_t head,
	input  logic        pop
);

	poll_entry_t entry_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;

	assign full  = (count_q == 2'd2);
	assign valid = (count_q != 2'd0);
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: rtl/core/prc_back.sv
`timescale 1ns / 1ps

module prc_back
	import prc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_valid,
	input  poll_entry_t      q_entry,
	output logic             q_pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [CMD_W-1:0] throttle_cmd,
	output logic [CMD_W-1:0] roll_cmd,
	output logic [CMD_W-1:0] pitch_cmd,
	output logic [CMD_W-1:0] yaw_cmd,
	output logic [CMD_W-1:0] aux_one_cmd,
	output logic [CMD_W-1:0] aux_two_cmd
);

	logic [CMD_W-1:0] cmd_q  [OUT_CHANNELS];
	logic [CMD_W-1:0] conv   [OUT_CHANNELS];
	logic             valid_q;
	logic [RAW_W-1:0] r;

	assign q_pop = q_valid && (!valid_q || out_ready);

	always_comb begin
		r = '0;
		for (int i = 0; i < OUT_CHANNELS; i++) begin
			r = q_entry.raw[i];
			if (i == 0) begin
				if (r < RAW_LOW) begin
					conv[i] = THR_MIN;
				end else if (r > RAW_HIGH) begin
					conv[i] = THR_MAX;
				end else begin
					conv[i] = CMD_W'(r - RAW_LOW);
				end
			end else begin
				if (r < RAW_LOW) begin
					conv[i] = AXIS_MIN;
				end else if (r > RAW_HIGH) begin
					conv[i] = AXIS_MAX;
				end else begin
					conv[i] = CMD_W'(r - RAW_MID);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			for (int i = 0; i < OUT_CHANNELS; i++) begin
				cmd_q[i] <= (i == 0) ? THR_MIN : AXIS_MAX;
			end
		end else begin
			if (q_pop) begin
				valid_q <= 1'b1;
				for (int i = 0; i < OUT_CHANNELS; i++) begin
					if (q_entry.upd[i]) begin
						cmd_q[i] <= conv[i];
					end
				end
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = valid_q;
	assign throttle_cmd = cmd_q[0];
	assign roll_cmd     = cmd_q[1];
	assign pitch_cmd    = cmd_q[2];
	assign yaw_cmd      = cmd_q[3];
	assign aux_one_cmd  = cmd_q[4];
	assign aux_two_cmd  = cmd_q[5];

endmodule

// File: rtl/core/ppm_rc_channel_decoder.sv
`timescale 1ns / 1ps
// channel   signals                                          transfer when
// input     in_valid, in_ready, req_type, timestamp, pin_high in_valid & in_ready
// output    out_valid, out_ready, six *_cmd fields           out_valid & out_ready
// config    wr_en, wr_index, wr_data                         wr_en
//
// one input transfer per cycle while in_ready; an edge updates the slot registers
// a poll is judged in the front and passes a two-entry queue to the back,
// via a queue entry register into the output register when the back is free
// in_ready drops only while the queue holds two polls
// arst_n sets all but queue entries to power-up values at once, no clearing pass

module ppm_rc_channel_decoder
	import prc_pkg::*;
#(
	parameter int NUM_CHANNELS = 6
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  req_type,
	input  logic [TICK_W-1:0]     timestamp,
	input  logic                  pin_high,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [CMD_W-1:0]      throttle_cmd,
	output logic [CMD_W-1:0]      roll_cmd,
	output logic [CMD_W-1:0]      pitch_cmd,
	output logic [CMD_W-1:0]      yaw_cmd,
	output logic [CMD_W-1:0]      aux_one_cmd,
	output logic [CMD_W-1:0]      aux_two_cmd
);

	logic        q_push;
	logic        q_full;
	logic        q_valid;
	logic        q_pop;
	poll_entry_t push_entry;
	poll_entry_t head_entry;

	prc_front #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.req_type (req_type),
		.timestamp(timestamp),
		.pin_high (pin_high),
		.q_push   (q_push),
		.q_entry  (push_entry),
		.q_full   (q_full)
	);

	prc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_entry(push_entry),
		.full      (q_full),
		.valid     (q_valid),
		.head      (head_entry),
		.pop       (q_pop)
	);

	prc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_entry     (head_entry),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.throttle_cmd(throttle_cmd),
		.roll_cmd    (roll_cmd),
		.pitch_cmd   (pitch_cmd),
		.yaw_cmd     (yaw_cmd),
		.aux_one_cmd (aux_one_cmd),
		.aux_two_cmd (aux_two_cmd)
	);

	a_edge_no_push: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && !req_type) |-> !q_push)
		else $error("edge transfer pushed the queue");

	a_poll_push: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && req_type) |-> q_push)
		else $error("poll transfer not queued");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("push into full queue");

	a_pop_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> out_valid)
		else $error("popped poll not shown at output");

	a_throttle_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (throttle_cmd <= THR_MAX))
		else $error("throttle command out of range");

endmodule
